@@ hdl/cbt_pkg.sv @@
`timescale 1ns / 1ps

package cbt_pkg;

	localparam int FREQ_W  = 24;
	localparam int MS_W    = 16;
	localparam int CLOCK_W = 32;

	localparam logic [MS_W-1:0] INPUT_BOOST_MS_RST = MS_W'(64);
	localparam logic [MS_W-1:0] WAKE_BOOST_MS_RST  = MS_W'(1000);

	// event codes; codes 6 and 7 are left unused and are ignored
	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_INPUT      = 3'd1,
		OP_MAX_KICK   = 3'd2,
		OP_SCREEN_ON  = 3'd3,
		OP_SCREEN_OFF = 3'd4,
		OP_QUERY      = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		REG_BOOST_FREQ_LP   = 2'd0,
		REG_BOOST_FREQ_PERF = 2'd1,
		REG_INPUT_BOOST_MS  = 2'd2,
		REG_WAKE_BOOST_MS   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [MS_W-1:0]   kick_duration_ms;
		logic              cluster_is_low_power;
		logic [FREQ_W-1:0] policy_max_khz;
		logic [FREQ_W-1:0] policy_min_khz;
		logic [FREQ_W-1:0] hardware_min_khz;
	} evt_t;

	typedef struct packed {
		logic [FREQ_W-1:0] new_policy_min_khz;
		logic              display_on;
		logic              input_boosted;
		logic              max_boosted;
	} res_t;

endpackage

@@ hdl/cbt_channels.sv @@
`timescale 1ns / 1ps

// event channel
interface cbt_evt_if;
	logic          valid;
	logic          ready;
	cbt_pkg::evt_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

// result channel
interface cbt_res_if;
	logic          valid;
	logic          ready;
	cbt_pkg::res_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

// register write channel
interface cbt_cfg_if;
	logic                           valid;
	logic                           ready;
	cbt_pkg::cfg_idx_t              index;
	logic [cbt_pkg::FREQ_W-1:0]     data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ hdl/cpu_boost_timer_controller.sv @@
`timescale 1ns / 1ps

// CPU boost timer controller.
// Channels: evt carries one event word (tick, input event, max kick,
// screen on, screen off, policy query); res returns exactly one result
// word per event: the new policy minimum for a query (0 otherwise) plus
// the screen, input-boost and max-boost flags after the event. cfg is a
// write-only register port, always ready; write it only while idle.
// An accepted event sits in the input register and is evaluated against
// the controller state once the result slot is free; on that edge the state
// is updated and the result word is loaded, and res.valid then goes high.
// Throughput: one event per cycle unless res stalls; the limit is the single
// evaluation stage: a 32-bit add for kick expiry, then wrap-safe compare.
// Stall: when res is not taken, the result register holds, the input
// register fills, and then evt.ready drops until the result word leaves.
// Reset (arst_n low): flags, timers, running time and expiry clear; both
// boost frequencies return to 0, input boost to 64 ms, wake boost to
// 1000 ms; both registers empty.
module cpu_boost_timer_controller (
	input  logic  clk,
	input  logic  arst_n,
	cbt_cfg_if.sink   cfg,
	cbt_evt_if.sink   evt,
	cbt_res_if.source res
);
	import cbt_pkg::*;

	// configuration
	logic [FREQ_W-1:0] boost_lp_q, boost_perf_q;
	logic [MS_W-1:0]   input_ms_q, wake_ms_q;

	// controller state
	logic               awake_q, input_q, max_q;
	logic               in_pend_q, max_pend_q;
	logic [MS_W-1:0]    in_rem_q, max_rem_q;
	logic [CLOCK_W-1:0] now_q, expiry_q;

	// next state
	logic               awake_d, input_d, max_d;
	logic               in_pend_d, max_pend_d;
	logic [MS_W-1:0]    in_rem_d, max_rem_d;
	logic [CLOCK_W-1:0] now_d, expiry_d;

	// pipeline
	evt_t evt_s1;
	logic evt_vld_s1;
	res_t res_q;
	logic res_vld_q;
	res_t res_d;
	logic adv;

	// kick evaluation
	logic               kick_en;
	logic [MS_W-1:0]    kick_dur;
	logic [CLOCK_W-1:0] kick_target, kick_diff;
	logic               kick_skip;
	logic [FREQ_W-1:0]  bf, query_khz;

	// Advance the stage when an event is held and the result slot frees up.
	assign adv       = evt_vld_s1 && (!res_vld_q || res.ready);
	assign evt.ready = !evt_vld_s1 || adv;
	assign cfg.ready = 1'b1;
	assign res.valid = res_vld_q;
	assign res.item  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_lp_q   <= '0;
			boost_perf_q <= '0;
			input_ms_q   <= INPUT_BOOST_MS_RST;
			wake_ms_q    <= WAKE_BOOST_MS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BOOST_FREQ_LP:   boost_lp_q   <= cfg.data;
				REG_BOOST_FREQ_PERF: boost_perf_q <= cfg.data;
				REG_INPUT_BOOST_MS:  input_ms_q   <= cfg.data[MS_W-1:0];
				REG_WAKE_BOOST_MS:   wake_ms_q    <= cfg.data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: load on accept, drop once evaluated.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_vld_s1 <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			evt_vld_s1 <= 1'b1;
		end else if (adv) begin
			evt_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= evt.item;
		end
	end

	// Max kick: screen on uses the wake duration, and sets the awake flag
	// first, so its kick always sees the screen awake.
	always_comb begin
		kick_dur    = (evt_s1.op == OP_SCREEN_ON) ? wake_ms_q : evt_s1.kick_duration_ms;
		kick_target = now_q + CLOCK_W'(kick_dur);
		kick_diff   = expiry_q - kick_target;
		// a later expiry already in effect wins (signed difference above zero)
		kick_skip   = (kick_diff != '0) && !kick_diff[CLOCK_W-1];
		kick_en     = ((evt_s1.op == OP_SCREEN_ON) ||
			(evt_s1.op == OP_MAX_KICK && awake_q)) && !kick_skip;
	end

	// Policy query: max boost wins, a disabled boost frequency keeps the
	// policy minimum, an input boost caps at the policy maximum.
	always_comb begin
		bf = evt_s1.cluster_is_low_power ? boost_lp_q : boost_perf_q;
		if (max_q) begin
			query_khz = evt_s1.policy_max_khz;
		end else if (bf == '0) begin
			query_khz = evt_s1.policy_min_khz;
		end else if (input_q) begin
			query_khz = (evt_s1.policy_max_khz < bf) ? evt_s1.policy_max_khz : bf;
		end else begin
			query_khz = evt_s1.hardware_min_khz;
		end
	end

	always_comb begin
		awake_d    = awake_q;
		input_d    = input_q;
		max_d      = max_q;
		in_pend_d  = in_pend_q;
		max_pend_d = max_pend_q;
		in_rem_d   = in_rem_q;
		max_rem_d  = max_rem_q;
		now_d      = now_q;
		expiry_d   = expiry_q;
		res_d.new_policy_min_khz = '0;

		case (evt_s1.op)
			OP_TICK: begin
				now_d = now_q + CLOCK_W'(1);
				// a count of 0 or 1 expires on this tick
				if (in_pend_q) begin
					if (in_rem_q <= MS_W'(1)) begin
						in_pend_d = 1'b0;
						in_rem_d  = '0;
						input_d   = 1'b0;
					end else begin
						in_rem_d = in_rem_q - MS_W'(1);
					end
				end
				if (max_pend_q) begin
					if (max_rem_q <= MS_W'(1)) begin
						max_pend_d = 1'b0;
						max_rem_d  = '0;
						max_d      = 1'b0;
					end else begin
						max_rem_d = max_rem_q - MS_W'(1);
					end
				end
			end
			OP_INPUT: begin
				if (awake_q) begin
					input_d   = 1'b1;
					in_pend_d = 1'b1;
					in_rem_d  = input_ms_q;
				end
			end
			OP_MAX_KICK, OP_SCREEN_ON: begin
				if (evt_s1.op == OP_SCREEN_ON) begin
					awake_d = 1'b1;
				end
				if (kick_en) begin
					expiry_d   = kick_target;
					max_rem_d  = kick_dur;
					max_pend_d = 1'b1;
					max_d      = 1'b1;
				end
			end
			OP_SCREEN_OFF: begin
				// cancel both timers; the recorded expiry is kept
				awake_d    = 1'b0;
				input_d    = 1'b0;
				max_d      = 1'b0;
				in_pend_d  = 1'b0;
				max_pend_d = 1'b0;
				in_rem_d   = '0;
				max_rem_d  = '0;
			end
			OP_QUERY: begin
				res_d.new_policy_min_khz = query_khz;
			end
			default: ;
		endcase

		res_d.display_on    = awake_d;
		res_d.input_boosted = input_d;
		res_d.max_boosted   = max_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awake_q    <= 1'b0;
			input_q    <= 1'b0;
			max_q      <= 1'b0;
			in_pend_q  <= 1'b0;
			max_pend_q <= 1'b0;
			in_rem_q   <= '0;
			max_rem_q  <= '0;
			now_q      <= '0;
			expiry_q   <= '0;
		end else if (adv) begin
			awake_q    <= awake_d;
			input_q    <= input_d;
			max_q      <= max_d;
			in_pend_q  <= in_pend_d;
			max_pend_q <= max_pend_d;
			in_rem_q   <= in_rem_d;
			max_rem_q  <= max_rem_d;
			now_q      <= now_d;
			expiry_q   <= expiry_d;
		end
	end

	// Result register: hold while stalled, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	// boosts only live while the screen is awake
	a_boost_needs_awake: assert property (@(posedge clk) disable iff (!arst_n)
		(input_q || max_q) |-> awake_q)
		else $error("boost flag set while screen asleep");

	a_input_timer_tracks_flag: assert property (@(posedge clk) disable iff (!arst_n)
		in_pend_q == input_q)
		else $error("input timer and input boost flag disagree");

	a_max_timer_tracks_flag: assert property (@(posedge clk) disable iff (!arst_n)
		max_pend_q == max_q)
		else $error("max timer and max boost flag disagree");

	a_state_holds_without_event: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(now_q) && $stable(expiry_q)))
		else $error("running time moved without an event");

	a_result_follows_event: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_vld_q)
		else $error("evaluated event produced no result word");

endmodule

@@ dv/cpu_boost_timer_controller_tb.sv @@
`timescale 1ns / 1ps

module cpu_boost_timer_controller_tb;
	import cbt_pkg::*;

	// event codes the block leaves unused; both must pass through as no-ops
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam logic [FREQ_W-1:0] KHZ_TOP = {FREQ_W{1'b1}};
	localparam logic [MS_W-1:0]   MS_TOP  = {MS_W{1'b1}};

	localparam int REPORT_LIMIT  = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 140;
	// wait after the last result word is taken; allow some slack
	localparam int SETTLE_CYCLES = 4;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_EVERY_K,
		RX_MOSTLY
	} rx_mode_t;

	// Tracks the controller state and queues the result word each event should
	// produce; compares the words coming out against that queue.
	class boost_tracker;
		logic [FREQ_W-1:0]  lp_khz;
		logic [FREQ_W-1:0]  perf_khz;
		logic [MS_W-1:0]    input_ms;
		logic [MS_W-1:0]    wake_ms;
		bit                 awake;
		bit                 input_on;
		bit                 max_on;
		bit                 input_armed;
		bit                 max_armed;
		logic [MS_W-1:0]    input_left;
		logic [MS_W-1:0]    max_left;
		logic [CLOCK_W-1:0] now_ms;
		logic [CLOCK_W-1:0] max_deadline;
		res_t               want_q[$];
		int                 mismatches;
		int                 words_seen;

		function new();
			lp_khz       = '0;
			perf_khz     = '0;
			input_ms     = INPUT_BOOST_MS_RST;
			wake_ms      = WAKE_BOOST_MS_RST;
			awake        = 1'b0;
			input_on     = 1'b0;
			max_on       = 1'b0;
			input_armed  = 1'b0;
			max_armed    = 1'b0;
			input_left   = '0;
			max_left     = '0;
			now_ms       = '0;
			max_deadline = '0;
			mismatches   = 0;
			words_seen   = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [FREQ_W-1:0] v);
			case (idx)
			REG_BOOST_FREQ_LP:   lp_khz = v;
			REG_BOOST_FREQ_PERF: perf_khz = v;
			REG_INPUT_BOOST_MS:  input_ms = v[MS_W-1:0];
			REG_WAKE_BOOST_MS:   wake_ms = v[MS_W-1:0];
			default: ;
			endcase
		endfunction

		// skip the kick when the deadline on record lies later (wrap-safe)
		function void kick_max(logic [MS_W-1:0] dur);
			logic [CLOCK_W-1:0] target;
			logic [CLOCK_W-1:0] lead;
			if (!awake)
				return;
			target = now_ms + CLOCK_W'(dur);
			lead   = max_deadline - target;
			if (lead != '0 && !lead[CLOCK_W-1])
				return;
			max_deadline = target;
			max_left     = dur;
			max_armed    = 1'b1;
			max_on       = 1'b1;
		endfunction

		function void step_ms();
			now_ms = now_ms + 1'b1;
			if (input_armed) begin
				if (input_left <= 1) begin
					input_armed = 1'b0;
					input_left  = '0;
					input_on    = 1'b0;
				end else begin
					input_left = input_left - 1'b1;
				end
			end
			if (max_armed) begin
				if (max_left <= 1) begin
					max_armed = 1'b0;
					max_left  = '0;
					max_on    = 1'b0;
				end else begin
					max_left = max_left - 1'b1;
				end
			end
		endfunction

		function logic [FREQ_W-1:0] floor_khz(evt_t e);
			logic [FREQ_W-1:0] boost;
			boost = e.cluster_is_low_power ? lp_khz : perf_khz;
			if (max_on)
				return e.policy_max_khz;
			if (boost == '0)
				return e.policy_min_khz;
			if (input_on)
				return (e.policy_max_khz < boost) ? e.policy_max_khz : boost;
			return e.hardware_min_khz;
		endfunction

		function void note_event(evt_t e);
			res_t w;
			w.new_policy_min_khz = '0;
			case (e.op)
			OP_TICK: step_ms();
			OP_INPUT: if (awake) begin
				input_on    = 1'b1;
				input_armed = 1'b1;
				input_left  = input_ms;
			end
			OP_MAX_KICK: kick_max(e.kick_duration_ms);
			OP_SCREEN_ON: begin
				awake = 1'b1;
				kick_max(wake_ms);
			end
			OP_SCREEN_OFF: begin
				awake       = 1'b0;
				input_armed = 1'b0;
				input_left  = '0;
				max_armed   = 1'b0;
				max_left    = '0;
				input_on    = 1'b0;
				max_on      = 1'b0;
			end
			OP_QUERY: w.new_policy_min_khz = floor_khz(e);
			default: ;
			endcase
			w.display_on    = awake;
			w.input_boosted = input_on;
			w.max_boosted   = max_on;
			want_q.push_back(w);
		endfunction

		function void check_word(res_t got);
			res_t want;
			bit   bad;
			words_seen++;
			if (want_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("word %0d unexpected: khz=%0d awake=%0b in=%0b max=%0b",
						words_seen, got.new_policy_min_khz, got.display_on,
						got.input_boosted, got.max_boosted);
				return;
			end
			want = want_q.pop_front();
			bad  = (got.new_policy_min_khz !== want.new_policy_min_khz)
				|| (got.display_on !== want.display_on)
				|| (got.input_boosted !== want.input_boosted)
				|| (got.max_boosted !== want.max_boosted);
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("word %0d: khz %0d/%0d awk %0b/%0b in %0b/%0b max %0b/%0b (exp/act)",
						words_seen, want.new_policy_min_khz, got.new_policy_min_khz,
						want.display_on, got.display_on,
						want.input_boosted, got.input_boosted,
						want.max_boosted, got.max_boosted);
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cbt_cfg_if cfg_ch();
	cbt_evt_if evt_ch();
	cbt_res_if res_ch();

	boost_tracker book = new();

	// words left in the current sender burst, and receiver hold-off request
	int burst_left   = 0;
	int rx_hold_left = 0;

	cpu_boost_timer_controller u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.evt   (evt_ch),
		.res   (res_ch)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog: far beyond the slowest legal run (every word waiting out the
	// longest sender gap and receiver stall, plus the long hold-off).
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// Check every result word the receiver takes, oldest expectation first.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			book.check_word(res_ch.item);
	end

	// Receiver: switch among stall patterns in segments of random length.
	// A hold-off request from the stimulus side overrides the pattern and
	// keeps ready low for that many cycles so the block backs up.
	initial begin
		rx_mode_t mode;
		int       seg;
		int       k;
		int       cnt;
		cnt = 0;
		res_ch.ready <= 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			seg  = $urandom_range(20, 150);
			k    = $urandom_range(2, 6);
			repeat (seg) begin
				@(posedge clk);
				cnt++;
				if (rx_hold_left > 0) begin
					res_ch.ready <= 1'b0;
					rx_hold_left--;
				end else begin
					case (mode)
					RX_OPEN:    res_ch.ready <= 1'b1;
					RX_COIN:    res_ch.ready <= 1'($urandom_range(0, 1));
					RX_EVERY_K: res_ch.ready <= (cnt % k == 0);
					default:    res_ch.ready <= ($urandom_range(0, 9) != 0);
					endcase
				end
			end
		end
	end

	function automatic logic [FREQ_W-1:0] rand_khz();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return KHZ_TOP;
		return FREQ_W'($urandom);
	endfunction

	function automatic evt_t make_evt(logic [2:0] op, logic [MS_W-1:0] dur, bit lp,
			logic [FREQ_W-1:0] pmax, logic [FREQ_W-1:0] pmin, logic [FREQ_W-1:0] hmin);
		evt_t e;
		e.op                   = op;
		e.kick_duration_ms     = dur;
		e.cluster_is_low_power = lp;
		e.policy_max_khz       = pmax;
		e.policy_min_khz       = pmin;
		e.hardware_min_khz     = hmin;
		return e;
	endfunction

	// Mostly ticks and queries with enough screen-on and input traffic to keep
	// the boosts cycling; wide phases also use full-range kick durations.
	function automatic evt_t rand_event(bit wide);
		evt_t e;
		int   pick;
		pick = $urandom_range(0, 99);
		if (wide && $urandom_range(0, 3) == 0)
			e.kick_duration_ms = MS_W'($urandom);
		else
			e.kick_duration_ms = MS_W'($urandom_range(0, 40));
		e.cluster_is_low_power = 1'($urandom_range(0, 1));
		e.policy_max_khz       = rand_khz();
		e.policy_min_khz       = rand_khz();
		e.hardware_min_khz     = rand_khz();
		if (pick < 34)
			e.op = OP_TICK;
		else if (pick < 59)
			e.op = OP_QUERY;
		else if (pick < 71)
			e.op = OP_INPUT;
		else if (pick < 83)
			e.op = OP_MAX_KICK;
		else if (pick < 92)
			e.op = OP_SCREEN_ON;
		else if (pick < 97)
			e.op = OP_SCREEN_OFF;
		else if (pick < 99)
			e.op = OP_SPARE_LO;
		else
			e.op = OP_SPARE_HI;
		return e;
	endfunction

	// Offer one event word and hold it until taken. Bursts of random length
	// are separated by random gaps unless the caller wants a steady stream.
	task automatic send_event(input evt_t e, input bit steady);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				evt_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		evt_ch.valid <= 1'b1;
		evt_ch.item  <= e;
		@(posedge clk);
		while (!evt_ch.ready)
			@(posedge clk);
		book.note_event(e);
	endtask

	// Leave valid high; the caller drops it after the last register.
	task automatic write_reg(input cfg_idx_t idx, input logic [FREQ_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		book.set_reg(idx, v);
	endtask

	task automatic write_config(input logic [FREQ_W-1:0] lp, input logic [FREQ_W-1:0] perf,
			input logic [MS_W-1:0] in_ms, input logic [MS_W-1:0] wake);
		write_reg(REG_BOOST_FREQ_LP, lp);
		write_reg(REG_BOOST_FREQ_PERF, perf);
		write_reg(REG_INPUT_BOOST_MS, FREQ_W'(in_ms));
		write_reg(REG_WAKE_BOOST_MS, FREQ_W'(wake));
		cfg_ch.valid <= 1'b0;
	endtask

	// Drop the event offer, wait for every queued word, then let the
	// pipeline settle before touching the registers.
	task automatic wait_idle();
		evt_ch.valid <= 1'b0;
		burst_left = 0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [FREQ_W-1:0] lp;
		logic [FREQ_W-1:0] perf;
		logic [MS_W-1:0]   in_ms;
		logic [MS_W-1:0]   wake;
		bit                wide;
		bit                steady;

		arst_n       <= 1'b0;
		evt_ch.valid <= 1'b0;
		evt_ch.item  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_BOOST_FREQ_LP;
		cfg_ch.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Screen asleep at reset settings: query with boost freq 0 returns the
		// policy minimum; input events, kicks and the unused codes do nothing.
		send_event(make_evt(OP_QUERY, '0, 1'b0, 24'd2000, 24'd700, 24'd100), 1'b0);
		send_event(make_evt(OP_INPUT, '0, 1'b1, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_MAX_KICK, MS_TOP, 1'b0, KHZ_TOP, KHZ_TOP, KHZ_TOP), 1'b0);
		send_event(make_evt(OP_SPARE_LO, MS_TOP, 1'b1, KHZ_TOP, KHZ_TOP, KHZ_TOP), 1'b0);
		send_event(make_evt(OP_SPARE_HI, MS_TOP, 1'b1, KHZ_TOP, KHZ_TOP, KHZ_TOP), 1'b0);
		wait_idle();

		// Directed walk: short input and wake boosts so expiry shows up quickly.
		write_config(24'd1500000, KHZ_TOP, 16'd2, 16'd3);
		// wake boost, then a shorter kick that must be skipped and a longer one
		send_event(make_evt(OP_SCREEN_ON, '0, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_QUERY, '0, 1'b0, KHZ_TOP, 24'd5, 24'd1), 1'b0);
		send_event(make_evt(OP_MAX_KICK, 16'd1, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_MAX_KICK, 16'd6, 1'b0, '0, '0, '0), 1'b0);
		// screen off clears both boosts; the later deadline stays on record
		send_event(make_evt(OP_SCREEN_OFF, '0, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_QUERY, '0, 1'b1, 24'd2000000, 24'd9, '0), 1'b0);
		// wake kick ends before the deadline on record, so no max boost
		send_event(make_evt(OP_SCREEN_ON, '0, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_QUERY, '0, 1'b1, 24'd2000000, 24'd9, KHZ_TOP), 1'b0);
		// input boost: smaller of policy max and cluster boost, both ways round
		send_event(make_evt(OP_INPUT, '0, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_QUERY, '0, 1'b1, 24'd2000000, 24'd9, 24'd3), 1'b0);
		send_event(make_evt(OP_QUERY, '0, 1'b0, 24'd123, 24'd9, 24'd3), 1'b0);
		send_event(make_evt(OP_TICK, '0, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_TICK, '0, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_QUERY, '0, 1'b0, 24'd123, 24'd9, 24'd3), 1'b0);
		// run up to the deadline; a zero kick landing on it is taken and
		// expires on the very next tick
		repeat (4) send_event(make_evt(OP_TICK, '0, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_MAX_KICK, '0, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_QUERY, '0, 1'b1, 24'd777, 24'd9, 24'd3), 1'b0);
		send_event(make_evt(OP_TICK, '0, 1'b0, '0, '0, '0), 1'b0);
		send_event(make_evt(OP_QUERY, '0, 1'b1, 24'd777, 24'd9, 24'd3), 1'b0);
		send_event(make_evt(OP_SPARE_LO, '0, 1'b0, '0, '0, '0), 1'b0);
		wait_idle();

		// Random phases, each under its own register setting. The one with
		// the longest wake and input boosts runs last so its far deadline
		// does not block kicks in the others.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wide   = 1'b0;
			steady = 1'b0;
			case (phase)
			0: begin
				lp = rand_khz(); perf = rand_khz(); in_ms = 16'd5; wake = 16'd10;
			end
			1: begin
				lp = '0; perf = KHZ_TOP; in_ms = '0; wake = '0;
				steady = 1'b1;
			end
			2: begin
				lp = rand_khz(); perf = rand_khz();
				in_ms = MS_W'($urandom_range(1, 30)); wake = MS_W'($urandom_range(1, 40));
			end
			3: begin
				lp = KHZ_TOP; perf = '0; in_ms = 16'd1; wake = 16'd1;
			end
			4: begin
				lp = rand_khz(); perf = rand_khz();
				in_ms = MS_W'($urandom_range(3, 12)); wake = MS_W'($urandom_range(5, 25));
			end
			default: begin
				lp = KHZ_TOP; perf = KHZ_TOP; in_ms = MS_TOP; wake = MS_TOP;
				wide = 1'b1;
			end
			endcase
			write_config(lp, perf, in_ms, wake);
			// stall the receiver while the sender streams, so the block fills
			if (steady)
				rx_hold_left = HOLD_CYCLES;
			repeat (PHASE_ITEMS) send_event(rand_event(wide), steady);
			wait_idle();
		end

		if (book.mismatches == 0 && book.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
